// ===== hw/rtl/mcspg_pkg.sv =====
package mcspg_pkg;

  // Defaults for the top-level parameters.
  localparam int MCSPG_MOTORS  = 4;
  localparam int MCSPG_TICK_US = 100;

  // Field widths.
  localparam int KIND_W  = 3;
  localparam int CHAN_W  = 2;
  localparam int STEP_W  = 24;
  localparam int PULSE_W = 20;
  localparam int TICKS_W = STEP_W + 1;
  localparam int HALF_W  = 14;
  localparam int LEVEL_W = 4;

  // Channel bus widths.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  localparam logic [HALF_W-1:0] HALF_MAX = '1;
  localparam logic [HALF_W-1:0] HALF_ONE = HALF_W'(1);

  // Depth of the command queue between front and back.
  localparam int QDEPTH = 2;

  // Command kinds as they arrive on the input channel.
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PAUSE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESUME = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STOP   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd5;

  // Operation after classification; OP_NONE covers unused kinds and
  // channels that do not exist.
  typedef enum logic [2:0] {
    OP_TICK,
    OP_START,
    OP_PAUSE,
    OP_RESUME,
    OP_STOP,
    OP_QUERY,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [CHAN_W-1:0]  channel;
    logic [STEP_W-1:0]  step_count;
    logic               dir_value;
    logic [PULSE_W-1:0] pulse_width;
  } cmd_t;

endpackage

// ===== hw/rtl/mcspg_front.sv =====
module mcspg_front
  import mcspg_pkg::*;
#(
  parameter int MOTORS = MCSPG_MOTORS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [KIND_W-1:0]    in_tuser,  // kind
  input  logic [IN_DATA_W-1:0] in_tdata,  // channel, step_count, dir_value, pulse_width
  input  logic                 q_full,
  output logic                 q_push,
  output cmd_t                 q_item
);

  logic ch_ok;
  logic seen_r;

  // Take a transfer whenever the queue has room.
  assign in_tready = ~q_full;
  assign q_push    = in_tvalid & in_tready;

  // A command addresses a channel only if that channel is built.
  assign ch_ok = 32'(in_tdata[1:0]) < MOTORS;

  // Classify the incoming command.
  always_comb begin
    q_item.channel     = in_tdata[1:0];
    q_item.step_count  = in_tdata[25:2];
    q_item.dir_value   = in_tdata[26];
    q_item.pulse_width = in_tdata[46:27];
    case (in_tuser)
      KIND_TICK:   q_item.op = OP_TICK;
      KIND_START:  q_item.op = ch_ok ? OP_START : OP_NONE;
      KIND_PAUSE:  q_item.op = ch_ok ? OP_PAUSE : OP_NONE;
      KIND_RESUME: q_item.op = ch_ok ? OP_RESUME : OP_NONE;
      KIND_STOP:   q_item.op = ch_ok ? OP_STOP : OP_NONE;
      KIND_QUERY:  q_item.op = ch_ok ? OP_QUERY : OP_NONE;
      default:     q_item.op = OP_NONE;
    endcase
  end

  // Marks that at least one transfer has been taken since reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (q_push) begin
      seen_r <= 1'b1;
    end
  end

  // Every transfer that is taken is recorded on the next cycle.
  property p_pad_zero_ignored;
    @(posedge clk) disable iff (!rst_n)
      q_push |=> seen_r;
  endproperty
  a_pad_zero_ignored: assert property (p_pad_zero_ignored)
    else $error("transfer taken but not recorded");

endmodule

// ===== hw/rtl/mcspg_fifo.sv =====
module mcspg_fifo
  import mcspg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_item,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = count_r == CNT_W'(QDEPTH);
  assign valid = count_r != '0;
  assign head  = mem_r[rd_ptr_r];

  // Pointer and fill-count bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/mcspg_back.sv =====
module mcspg_back
  import mcspg_pkg::*;
#(
  parameter int MOTORS         = MCSPG_MOTORS,
  parameter int TICK_PERIOD_US = MCSPG_TICK_US
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  cmd_t                  q_item,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // accepted, steps_left, busy_res, halted, step_levels, dir_levels
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int DIV_L = $clog2(TICK_PERIOD_US);
  localparam int DIV_S = PULSE_W + DIV_L;
  // Rounded-up reciprocal of the tick period; exact for every PULSE_W-bit width.
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << DIV_S) + 64'(TICK_PERIOD_US) - 64'd1) / 64'(TICK_PERIOD_US);
  localparam logic [PULSE_W:0] RECIP = (PULSE_W + 1)'(RECIP_WIDE);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_DIV,
    ST_LOAD,
    ST_RESULT
  } state_t;

  state_t state_r;
  state_t disp_state_nxt;

  // Per-channel state.
  logic [TICKS_W-1:0] ticks_r [MOTORS];
  logic [HALF_W-1:0]  half_r  [MOTORS];
  logic [HALF_W-1:0]  cnt_r   [MOTORS];
  logic [MOTORS-1:0]  step_r;
  logic [MOTORS-1:0]  dir_r;
  logic [MOTORS-1:0]  pause_r;

  // Sequencer and divider registers.
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     cidx_r;
  logic [STEP_W-1:0]    csteps_r;
  logic                 cdir_r;
  logic [PULSE_W-1:0]   div_q_r;

  // Result fields waiting for the output register.
  logic              res_acc_r;
  logic [STEP_W-1:0] res_left_r;
  logic              res_busy_r;
  logic              res_hold_r;
  logic              res_acc_nxt;
  logic [STEP_W-1:0] res_left_nxt;
  logic              res_busy_nxt;
  logic              res_hold_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [IDX_W-1:0]     head_idx;
  logic [IDX_W-1:0]     sel_idx;
  logic [TICKS_W-1:0]   cur_ticks;
  logic [HALF_W-1:0]    cur_half;
  logic [HALF_W-1:0]    cur_cnt;
  logic                 cur_pause;
  logic [2*PULSE_W:0]   recip_prod;
  logic [PULSE_W-1:0]   quot;
  logic [HALF_W-1:0]    half_nxt;
  logic [LEVEL_W-1:0]   step_lv;
  logic [LEVEL_W-1:0]   dir_lv;
  logic                 out_free;
  logic                 res_load;
  logic                 half_zero;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = ~out_valid_r | out_tready;
  assign res_load   = (state_r == ST_RESULT) & out_free;
  assign q_pop      = (state_r == ST_IDLE) & q_valid;
  assign head_idx   = IDX_W'(q_item.channel);

  // Channel selected for this cycle's read.
  always_comb begin
    case (state_r)
      ST_TICK: sel_idx = idx_r;
      ST_LOAD: sel_idx = cidx_r;
      default: sel_idx = head_idx;
    endcase
  end

  assign cur_ticks = ticks_r[sel_idx];
  assign cur_half  = half_r[sel_idx];
  assign cur_cnt   = cnt_r[sel_idx];
  assign cur_pause = pause_r[sel_idx];

  // Pulse width over the tick period by multiplying with the reciprocal.
  assign recip_prod = div_q_r * RECIP;
  assign quot       = PULSE_W'(recip_prod >> DIV_S);

  // Clamp the quotient into the half-period range.
  always_comb begin
    if (div_q_r > PULSE_W'(HALF_MAX)) begin
      half_nxt = HALF_MAX;
    end else if (div_q_r == '0) begin
      half_nxt = HALF_ONE;
    end else begin
      half_nxt = div_q_r[HALF_W-1:0];
    end
  end

  // Result fields and following state for the command at the queue head.
  always_comb begin
    res_acc_nxt    = 1'b0;
    res_left_nxt   = '0;
    res_busy_nxt   = 1'b0;
    res_hold_nxt   = 1'b0;
    disp_state_nxt = ST_RESULT;
    case (q_item.op)
      OP_TICK: begin
        disp_state_nxt = ST_TICK;
      end
      OP_START: begin
        if (cur_ticks == '0) begin
          if (q_item.pulse_width != '0) begin
            disp_state_nxt = ST_DIV;
          end else begin
            res_acc_nxt = 1'b1;
          end
        end
      end
      OP_STOP: begin
        res_left_nxt = cur_ticks[TICKS_W-1:1];
        res_busy_nxt = cur_ticks[0];
        res_hold_nxt = cur_pause;
      end
      OP_QUERY: begin
        res_left_nxt = cur_ticks[TICKS_W-1:1];
        res_busy_nxt = cur_ticks != '0;
        res_hold_nxt = cur_pause;
      end
      default: begin
      end
    endcase
  end

  // Line levels of the first four channels.
  for (genvar g = 0; g < LEVEL_W; g++) begin : g_lv
    if (g < MOTORS) begin : g_on
      assign step_lv[g] = step_r[g];
      assign dir_lv[g]  = dir_r[g];
    end else begin : g_off
      assign step_lv[g] = 1'b0;
      assign dir_lv[g]  = 1'b0;
    end
  end

  always_comb begin
    half_zero = 1'b0;
    for (int i = 0; i < MOTORS; i++) begin
      half_zero = half_zero | (half_r[i] == '0);
    end
  end

  // Command sequencer with channel state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      step_r      <= '0;
      dir_r       <= '0;
      pause_r     <= '0;
      for (int i = 0; i < MOTORS; i++) begin
        ticks_r[i] <= '0;
        half_r[i]  <= HALF_ONE;
        cnt_r[i]   <= '0;
      end
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            res_acc_r  <= res_acc_nxt;
            res_left_r <= res_left_nxt;
            res_busy_r <= res_busy_nxt;
            res_hold_r <= res_hold_nxt;
            state_r    <= disp_state_nxt;
            case (q_item.op)
              OP_TICK: begin
                idx_r <= '0;
              end
              OP_START: begin
                if (cur_ticks == '0) begin
                  if (q_item.pulse_width != '0) begin
                    cidx_r   <= head_idx;
                    csteps_r <= q_item.step_count;
                    cdir_r   <= q_item.dir_value;
                    div_q_r  <= q_item.pulse_width;
                  end else begin
                    ticks_r[head_idx] <= {q_item.step_count, 1'b0};
                    cnt_r[head_idx]   <= cur_half;
                    dir_r[head_idx]   <= q_item.dir_value;
                    pause_r[head_idx] <= 1'b0;
                  end
                end
              end
              OP_PAUSE: begin
                pause_r[head_idx] <= 1'b1;
              end
              OP_RESUME: begin
                pause_r[head_idx] <= 1'b0;
              end
              OP_STOP: begin
                // Keep one edge if a pulse is half done.
                ticks_r[head_idx] <= {{(TICKS_W-1){1'b0}}, cur_ticks[0]};
              end
              default: begin
              end
            endcase
          end
        end
        ST_TICK: begin
          // One channel per cycle counts down; an edge on reaching the end.
          if (!cur_pause) begin
            if (cur_cnt <= HALF_ONE) begin
              cnt_r[idx_r] <= cur_half;
              if (cur_ticks != '0) begin
                step_r[idx_r]  <= ~step_r[idx_r];
                ticks_r[idx_r] <= cur_ticks - 1'b1;
              end
            end else begin
              cnt_r[idx_r] <= cur_cnt - 1'b1;
            end
          end
          if (idx_r == IDX_W'(MOTORS - 1)) begin
            state_r <= ST_RESULT;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_DIV: begin
          div_q_r <= quot;
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          half_r[cidx_r]  <= half_nxt;
          cnt_r[cidx_r]   <= half_nxt;
          ticks_r[cidx_r] <= {csteps_r, 1'b0};
          dir_r[cidx_r]   <= cdir_r;
          pause_r[cidx_r] <= 1'b0;
          res_acc_r       <= 1'b1;
          state_r         <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_free) begin
            out_data_r <= {5'b0, dir_lv, step_lv, res_hold_r, res_busy_r,
                           res_left_r, res_acc_r};
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // A result appears only from the result state.
  property p_result_from_result_state;
    @(posedge clk) disable iff (!rst_n)
      $rose(out_valid_r) |-> $past(state_r == ST_RESULT);
  endproperty
  a_result_from_result_state: assert property (p_result_from_result_state)
    else $error("result raised outside the result state");

  // The tick sweep never addresses a channel that is not built.
  property p_tick_index_range;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ST_TICK) |-> (32'(idx_r) < MOTORS);
  endproperty
  a_tick_index_range: assert property (p_tick_index_range)
    else $error("tick sweep index out of range");

  // Loading a new period only follows a finished division.
  property p_load_after_div;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ST_LOAD) |-> $past(state_r == ST_DIV);
  endproperty
  a_load_after_div: assert property (p_load_after_div)
    else $error("period load without division");

  // A half period of zero would never be produced by reset or a start.
  property p_half_nonzero;
    @(posedge clk) disable iff (!rst_n)
      !half_zero;
  endproperty
  a_half_nonzero: assert property (p_half_nonzero)
    else $error("half period reached zero");

endmodule

// ===== hw/rtl/multi_channel_step_pulse_generator_top.sv =====
// A transfer enters the queue and is dispatched from idle; a tick then sweeps every
// channel in the tick state, a start with a new pulse width passes the divide state
// (the reciprocal divide) and the load state, and others go straight to the result
// state. The back end works on one command at a time; a two-entry queue feeds it.
// Reset (rst_n low, synchronous) clears all channels: no ticks left, lines low,
// unpaused, half period one.
module multi_channel_step_pulse_generator_top
  import mcspg_pkg::*;
#(
  parameter int MOTORS         = MCSPG_MOTORS,
  parameter int TICK_PERIOD_US = MCSPG_TICK_US
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // kind
  input  logic [KIND_W-1:0]     in_tuser,
  // channel, step_count, dir_value, pulse_width
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // accepted, steps_left, busy_res, halted, step_levels, dir_levels
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t push_item;
  cmd_t head_item;

  // Front end: takes transfers and classifies commands.
  mcspg_front #(
    .MOTORS (MOTORS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  // Command queue between the two halves.
  mcspg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (head_item)
  );

  // Back end: channel state, tick sweep, divider and result register.
  mcspg_back #(
    .MOTORS         (MOTORS),
    .TICK_PERIOD_US (TICK_PERIOD_US)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
